// ===== design/battery_level_gauge_defines.svh =====
// Assertion macros shared by the battery level gauge RTL.
// Used by files that include it; expects clk_i and rst_ni in scope.
`ifndef BATTERY_LEVEL_GAUGE_DEFINES_SVH
`define BATTERY_LEVEL_GAUGE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BLG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BLG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/blg_pkg.sv =====
// Package for the battery level gauge: payload types, field widths,
// discharge curve table and fixed arithmetic constants. No dependencies.
package blg_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned MV_W     = 16;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned DIVR_W   = 10;

  localparam int unsigned BATCH_SIZE_DEF = 16;
  localparam logic [DIVR_W-1:0] DIVR_RESET = 10'd200;

  // divider unit: quotient bits, pair counter, passes
  localparam int unsigned QUO_W   = 12;
  localparam int unsigned PAIR_W  = 3;
  localparam logic [PAIR_W-1:0] MEAN_PAIRS = 3'd6;
  localparam logic [PAIR_W-1:0] PCT_PAIRS  = 3'd2;
  localparam int unsigned PCT_QBITS = 4;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;

  // scaling: x / 100 through a reciprocal plus one correction step
  localparam int unsigned PROD_W   = SAMPLE_W + DIVR_W;
  localparam int unsigned RECIP_SH = 22;
  localparam logic [15:0] RECIP    = 16'd41943;
  localparam logic [6:0]  HUNDRED  = 7'd100;

  // interpolation
  localparam int unsigned CURVE_N = 12;
  localparam int unsigned CMV_W   = 13;
  localparam int unsigned SPAN_W  = 9;
  localparam int unsigned SPCT_W  = 4;
  localparam int unsigned NUM_W   = 12;
  localparam logic [MV_W-1:0]  MV_TOP   = 16'd4200;
  localparam logic [MV_W-1:0]  MV_EMPTY = 16'd3000;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_mv;
    logic                sample_ok;
  } blg_in_t;

  typedef struct packed {
    logic [MV_W-1:0]  battery_mv;
    logic [PCT_W-1:0] charge_percent;
  } blg_out_t;

  // discharge curve voltage points, highest first
  function automatic logic [CMV_W-1:0] curve_mv(input logic [3:0] k);
    logic [CMV_W-1:0] v;
    case (k)
      4'd0:    v = 13'd4200;
      4'd1:    v = 13'd4060;
      4'd2:    v = 13'd3980;
      4'd3:    v = 13'd3920;
      4'd4:    v = 13'd3870;
      4'd5:    v = 13'd3820;
      4'd6:    v = 13'd3790;
      4'd7:    v = 13'd3770;
      4'd8:    v = 13'd3740;
      4'd9:    v = 13'd3680;
      4'd10:   v = 13'd3450;
      4'd11:   v = 13'd3000;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // charge level at each curve point
  function automatic logic [PCT_W-1:0] curve_pct(input logic [3:0] k);
    logic [PCT_W-1:0] v;
    case (k)
      4'd0:    v = 7'd100;
      4'd1:    v = 7'd90;
      4'd2:    v = 7'd80;
      4'd3:    v = 7'd70;
      4'd4:    v = 7'd60;
      4'd5:    v = 7'd50;
      4'd6:    v = 7'd40;
      4'd7:    v = 7'd30;
      4'd8:    v = 7'd20;
      4'd9:    v = 7'd10;
      4'd10:   v = 7'd5;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/blg_front.sv =====
// Front end of the battery level gauge: takes sample requests, sums and
// counts the good ones, and queues one entry per batch with a good sample. Uses blg_pkg.
module blg_front #(
  parameter int unsigned BATCH_SIZE = blg_pkg::BATCH_SIZE_DEF,
  parameter int unsigned SUM_W      = 16,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned POS_W      = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  blg_pkg::blg_in_t     in_data_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output logic [SUM_W-1:0]     q_sum_o,
  output logic [CNT_W-1:0]     q_cnt_o
);

  logic [SUM_W-1:0] sum_q, sum_d, sum_inc;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             last, accept;

  // closing sample of the batch stalls only if the queue has no room
  assign last       = (pos_q == POS_W'(BATCH_SIZE - 1));
  assign in_ready_o = !last || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // running sum and count including the current request
  assign sum_inc = sum_q + (in_data_i.sample_ok ? SUM_W'(in_data_i.sample_mv) : '0);
  assign cnt_inc = cnt_q + CNT_W'(in_data_i.sample_ok);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (accept) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
        pos_d = '0;
      end else begin
        sum_d = sum_inc;
        cnt_d = cnt_inc;
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
    end
  end

  // an empty batch is dropped here
  assign q_push_o = accept && last && (cnt_inc != '0);
  assign q_sum_o  = sum_inc;
  assign q_cnt_o  = cnt_inc;

endmodule

// ===== design/blg_fifo.sv =====
// Short queue of closed batches (sum and good count) between front and
// back end of the battery level gauge. Uses blg_pkg for its default depth.
`include "battery_level_gauge_defines.svh"

module blg_fifo #(
  parameter int unsigned W     = 21,
  parameter int unsigned DEPTH = blg_pkg::QDEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && valid_o;

  // pointer and fill bookkeeping
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (wr) begin
      wp_d = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
    if (rd) begin
      rp_d = (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  `BLG_ASSERT_IMP(a_no_overflow, push_i, !full_o, "batch queue written while full")
  `BLG_ASSERT_IMP(a_no_underflow, pop_i, valid_o, "batch queue read while empty")
  `BLG_ASSERT_NXT(a_fill_up, wr && !rd, cnt_q == $past(cnt_q) + 1'b1, "queue fill count lost")

endmodule

// ===== design/blg_div.sv =====
// Shared restoring divider of the battery level gauge back end: two
// quotient bits per cycle over a preloaded partial remainder. Uses blg_pkg.
module blg_div #(
  parameter int unsigned DV_W = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DV_W-1:0]             rem_i,
  input  logic [blg_pkg::QUO_W-1:0]   low_i,
  input  logic [blg_pkg::PAIR_W-1:0]  pairs_i,
  input  logic [DV_W-1:0]             divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [blg_pkg::QUO_W-1:0]   quot_o
);

  localparam int unsigned QW = blg_pkg::QUO_W;

  logic                       busy_q, done_q;
  logic [blg_pkg::PAIR_W-1:0] cnt_q;
  logic [DV_W-1:0]            rem_q, rem_d, dvs_q, r1;
  logic [QW-1:0]              quo_q, quo_d;
  logic [DV_W:0]              t1, t2;
  logic                       ge1, ge2;

  // two compare-subtract steps; remainder stays below the divisor
  always_comb begin
    t1    = {rem_q, quo_q[QW-1]};
    ge1   = (t1 >= {1'b0, dvs_q});
    r1    = ge1 ? DV_W'(t1 - {1'b0, dvs_q}) : t1[DV_W-1:0];
    t2    = {r1, quo_q[QW-2]};
    ge2   = (t2 >= {1'b0, dvs_q});
    rem_d = ge2 ? DV_W'(t2 - {1'b0, dvs_q}) : t2[DV_W-1:0];
    quo_d = {quo_q[QW-3:0], ge1, ge2};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pairs_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == blg_pkg::PAIR_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      quo_q <= low_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== design/blg_back.sv =====
// Back end of the battery level gauge: mean, divider scaling, curve
// interpolation and the output register. Uses blg_pkg and blg_div.
`include "battery_level_gauge_defines.svh"

module blg_back #(
  parameter int unsigned SUM_W = 16,
  parameter int unsigned CNT_W = 5,
  parameter int unsigned DV_W  = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [blg_pkg::DIVR_W-1:0]    divider_i,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  logic [SUM_W-1:0]              q_sum_i,
  input  logic [CNT_W-1:0]              q_cnt_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output blg_pkg::blg_out_t             out_data_o
);

  localparam int unsigned QW = blg_pkg::QUO_W;
  localparam int unsigned MW = blg_pkg::MV_W;
  localparam int unsigned PW = blg_pkg::PCT_W;
  localparam int unsigned RW = blg_pkg::PROD_W + 16;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RCP  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;
  localparam logic [2:0] S_SEG  = 3'd5;
  localparam logic [2:0] S_PCT  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]                   st_q, st_d;
  logic [QW-1:0]                mean_q;
  logic [blg_pkg::PROD_W-1:0]   prod_q, fix_rem;
  logic [RW-1:0]                rcp_prod;
  logic [MW-1:0]                q0_q, batt_q;
  logic [PW-1:0]                base_q, pct_q;
  logic                         out_valid_q;
  blg_pkg::blg_out_t            out_q;

  logic                         div_start, div_busy, div_done, div_wait;
  logic [DV_W-1:0]              div_rem, div_dvs;
  logic [QW-1:0]                div_low, div_quot;
  logic [blg_pkg::PAIR_W-1:0]   div_pairs;

  logic                         seg_top, seg_low, out_load;
  logic [3:0]                   sel;
  logic [blg_pkg::SPAN_W-1:0]   seg_diff, seg_span;
  logic [blg_pkg::SPCT_W-1:0]   seg_spct;
  logic [blg_pkg::NUM_W-1:0]    seg_num;

  // curve segment: lowest index whose point is at or below the voltage
  always_comb begin
    sel = 4'd1;
    for (int k = blg_pkg::CURVE_N - 1; k >= 1; k--) begin
      if (batt_q >= MW'(blg_pkg::curve_mv(4'(k)))) begin
        sel = 4'(k);
      end
    end
  end

  assign seg_top  = (batt_q >= blg_pkg::MV_TOP);
  assign seg_low  = (batt_q < blg_pkg::MV_EMPTY);
  assign seg_diff = blg_pkg::SPAN_W'(batt_q - MW'(blg_pkg::curve_mv(sel)));
  assign seg_span = blg_pkg::SPAN_W'(blg_pkg::curve_mv(sel - 4'd1) - blg_pkg::curve_mv(sel));
  assign seg_spct = blg_pkg::SPCT_W'(blg_pkg::curve_pct(sel - 4'd1) - blg_pkg::curve_pct(sel));
  assign seg_num  = blg_pkg::NUM_W'(seg_diff) * blg_pkg::NUM_W'(seg_spct);

  // divider operands: mean pass from the queue, percent pass from the segment
  always_comb begin
    if (st_q == S_IDLE) begin
      div_rem   = DV_W'(q_sum_i >> QW);
      div_low   = q_sum_i[QW-1:0];
      div_pairs = blg_pkg::MEAN_PAIRS;
      div_dvs   = DV_W'(q_cnt_i);
    end else begin
      div_rem   = DV_W'(seg_num >> blg_pkg::PCT_QBITS);
      div_low   = {seg_num[blg_pkg::PCT_QBITS-1:0], {(QW - blg_pkg::PCT_QBITS){1'b0}}};
      div_pairs = blg_pkg::PCT_PAIRS;
      div_dvs   = DV_W'(seg_span);
    end
  end

  assign q_pop_o   = (st_q == S_IDLE) && q_valid_i;
  assign div_start = q_pop_o || ((st_q == S_SEG) && !seg_top && !seg_low);
  assign out_load  = (st_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign div_wait  = (st_q == S_DIV) || (st_q == S_PCT);

  blg_div #(
    .DV_W (DV_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_i     (div_rem),
    .low_i     (div_low),
    .pairs_i   (div_pairs),
    .divisor_i (div_dvs),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (q_valid_i) st_d = S_DIV;
      S_DIV:  if (div_done) st_d = S_MUL;
      S_MUL:  st_d = S_RCP;
      S_RCP:  st_d = S_FIX;
      S_FIX:  st_d = S_SEG;
      S_SEG:  st_d = (seg_top || seg_low) ? S_OUT : S_PCT;
      S_PCT:  if (div_done) st_d = S_OUT;
      S_OUT:  if (out_load) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // reciprocal estimate of x / 100, full-width product
  assign rcp_prod = RW'(prod_q) * RW'(blg_pkg::RECIP);

  // x mod 100 check after the reciprocal estimate
  assign fix_rem = prod_q - blg_pkg::PROD_W'(q0_q) * blg_pkg::PROD_W'(blg_pkg::HUNDRED);

  // datapath registers
  always_ff @(posedge clk_i) begin
    if ((st_q == S_DIV) && div_done) begin
      mean_q <= div_quot;
    end
    if (st_q == S_MUL) begin
      prod_q <= blg_pkg::PROD_W'(mean_q) * blg_pkg::PROD_W'(divider_i);
    end
    if (st_q == S_RCP) begin
      q0_q <= MW'(rcp_prod >> blg_pkg::RECIP_SH);
    end
    if (st_q == S_FIX) begin
      batt_q <= (fix_rem >= blg_pkg::PROD_W'(blg_pkg::HUNDRED)) ? q0_q + 1'b1 : q0_q;
    end
    if (st_q == S_SEG) begin
      base_q <= blg_pkg::curve_pct(sel);
      if (seg_top) begin
        pct_q <= blg_pkg::PCT_FULL;
      end else if (seg_low) begin
        pct_q <= blg_pkg::PCT_NONE;
      end
    end
    if ((st_q == S_PCT) && div_done) begin
      pct_q <= base_q + PW'(div_quot[blg_pkg::PCT_QBITS-1:0]);
    end
    if (out_load) begin
      out_q.battery_mv     <= batt_q;
      out_q.charge_percent <= pct_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BLG_ASSERT_IMP(a_div_free, div_start, !div_busy, "divider started while busy")
  `BLG_ASSERT_IMP(a_pct_range, out_valid_q, out_q.charge_percent <= blg_pkg::PCT_FULL, "charge high")
  `BLG_ASSERT_NXT(a_out_after_pct, (st_q == S_PCT) && div_done, st_q == S_OUT, "percent pass lost")
  `BLG_ASSERT_IMP(a_div_waited, div_wait, div_busy || div_done, "divider idle in wait state")

endmodule

// ===== design/battery_level_gauge.sv =====
// Battery level gauge top level: configuration register, front end, batch
// queue and back end. Uses blg_pkg, blg_front, blg_fifo and blg_back.
//
// Usage:
//   Sample requests arrive on in_valid_i/in_ready_o with in_data_i (mV plus
//   a good flag). Every BATCH_SIZE requests close a batch. A batch with at
//   least one good sample yields one result request on out_valid_o /
//   out_ready_i carrying battery_mv and charge_percent; an empty one yields
//   nothing. cfg_we_i writes the divider ratio (times 100) from cfg_data_i;
//   write it only while the block is idle.
//   Throughput: one sample per cycle while the queue has room. The back end
//   takes each batch through queue pop, mean division, three scaling steps,
//   segment lookup, percent division and the output load, and skips the
//   percent division when the voltage is off either end of the curve.
//   Batches of 16 or more samples run at full rate; shorter batches stall
//   the front once the queue fills.
//   Receiver stall: the result is held in the output register; the back end
//   waits with the next result, then the queue fills, then the closing
//   sample of a batch is refused.
//   Reset: sums, counts, queue and output valid clear; the divider ratio is 200.
module battery_level_gauge #(
  parameter int unsigned BATCH_SIZE = blg_pkg::BATCH_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [blg_pkg::DIVR_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  blg_pkg::blg_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output blg_pkg::blg_out_t           out_data_o
);

  localparam int unsigned SUM_W = $clog2(BATCH_SIZE * 4095 + 1);
  localparam int unsigned CNT_W = $clog2(BATCH_SIZE + 1);
  localparam int unsigned POS_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int unsigned DV_W  = (CNT_W > blg_pkg::SPAN_W) ? CNT_W : blg_pkg::SPAN_W;
  localparam int unsigned Q_W   = SUM_W + CNT_W;

  logic [blg_pkg::DIVR_W-1:0] divr_q;
  logic                       q_push, q_full, q_pop, q_valid;
  logic [SUM_W-1:0]           f_sum;
  logic [CNT_W-1:0]           f_cnt;
  logic [Q_W-1:0]             q_rdata;

  // divider ratio register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divr_q <= blg_pkg::DIVR_RESET;
    end else if (cfg_we_i) begin
      divr_q <= cfg_data_i;
    end
  end

  blg_front #(
    .BATCH_SIZE (BATCH_SIZE),
    .SUM_W      (SUM_W),
    .CNT_W      (CNT_W),
    .POS_W      (POS_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_sum_o    (f_sum),
    .q_cnt_o    (f_cnt)
  );

  blg_fifo #(
    .W     (Q_W),
    .DEPTH (blg_pkg::QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_sum, f_cnt}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  blg_back #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W),
    .DV_W  (DV_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .divider_i   (divr_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_sum_i     (q_rdata[Q_W-1:CNT_W]),
    .q_cnt_i     (q_rdata[CNT_W-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for battery_level_gauge: batches of pin samples in,
// averaged battery mV and charge percent out, checked against an internal predictor.
// Depends on blg_pkg and the battery_level_gauge RTL only.
module testbench;

  localparam int unsigned BATCH         = blg_pkg::BATCH_SIZE_DEF;
  localparam int unsigned MAX_GAP       = 18;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned KNEES         = 12;

  // single-cell discharge curve, highest voltage first
  localparam int unsigned KNEE_MV [KNEES] = '{4200, 4060, 3980, 3920, 3870, 3820,
                                              3790, 3770, 3740, 3680, 3450, 3000};
  localparam int unsigned KNEE_PCT [KNEES] = '{100, 90, 80, 70, 60, 50,
                                               40, 30, 20, 10, 5, 0};

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [blg_pkg::DIVR_W-1:0] cfg_data_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  blg_pkg::blg_in_t           in_data_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  blg_pkg::blg_out_t          out_data_o;

  // predictor state
  int unsigned                divider_x100;
  int unsigned                batch_sum;
  int unsigned                batch_good;
  int unsigned                batch_pos;
  blg_pkg::blg_out_t          gauge_expect_q[$];

  int unsigned                err_count;
  int unsigned                cycle_count;
  bit                         tx_idle;
  bit                         rx_idle;
  bit                         long_hold_req;

  battery_level_gauge u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock, period 12
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // charge level by truncating interpolation between curve knees
  function automatic int unsigned soc_from_mv(input int unsigned mv);
    int unsigned k;
    int unsigned pct;
    bit          found;
    pct = 0;
    found = 1'b0;
    if (mv >= KNEE_MV[0]) begin
      pct = 100;
    end else begin
      for (k = 1; k < KNEES && !found; k++) begin
        if (mv >= KNEE_MV[k]) begin
          pct = KNEE_PCT[k] + (mv - KNEE_MV[k]) * (KNEE_PCT[k-1] - KNEE_PCT[k]) /
                (KNEE_MV[k-1] - KNEE_MV[k]);
          found = 1'b1;
        end
      end
    end
    return pct;
  endfunction

  // update batch state for an accepted sample; queue a reading on batch close
  task automatic track_sample(input blg_pkg::blg_in_t s);
    int unsigned       mean;
    int unsigned       batt;
    int unsigned       pct;
    blg_pkg::blg_out_t r;
    if (s.sample_ok) begin
      batch_sum += s.sample_mv;
      batch_good++;
    end
    batch_pos++;
    if (batch_pos >= BATCH) begin
      if (batch_good != 0) begin
        mean = batch_sum / batch_good;
        batt = (mean * divider_x100 / 100) & 32'hFFFF;
        pct  = soc_from_mv(batt);
        r.battery_mv     = batt[blg_pkg::MV_W-1:0];
        r.charge_percent = pct[blg_pkg::PCT_W-1:0];
        gauge_expect_q.push_back(r);
      end
      batch_pos = 0;
      batch_sum = 0;
      batch_good = 0;
    end
  endtask

  // offer one sample request; valid stays up across back-to-back requests
  task automatic send_sample(input int unsigned mv, input bit ok);
    int unsigned      gap;
    blg_pkg::blg_in_t s;
    s.sample_mv = mv[blg_pkg::SAMPLE_W-1:0];
    s.sample_ok = ok;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    track_sample(s);
  endtask

  // drop valid, wait for every pending reading, then let the back end settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (gauge_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_divider(input int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value[blg_pkg::DIVR_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    divider_x100 = value & 32'h3FF;
  endtask

  function automatic int unsigned clamp_mv(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return unsigned'(v);
  endfunction

  // one batch of samples; most batches aim the battery voltage at the curve
  task automatic send_batch();
    int unsigned kind;
    int unsigned target;
    int unsigned pin;
    int unsigned lone;
    int unsigned i;
    int          noisy;
    kind = $urandom_range(0, 99);
    target = $urandom_range(2900, 4300);
    pin = (divider_x100 == 0) ? $urandom_range(0, 4095) : target * 100 / divider_x100;
    lone = $urandom_range(0, BATCH - 1);
    for (i = 0; i < BATCH; i++) begin
      if (kind < 60) begin
        noisy = int'(pin) + int'($urandom_range(0, 40)) - 20;
        send_sample(clamp_mv(noisy), $urandom_range(0, 9) != 0);
      end else if (kind < 80) begin
        send_sample($urandom_range(0, 4095), $urandom_range(0, 1) != 0);
      end else if (kind < 88) begin
        // empty batch or a single good sample
        send_sample($urandom_range(0, 4095), (kind < 84) ? 1'b0 : (i == lone));
      end else begin
        case ($urandom_range(0, 2))
          0:       send_sample(0, $urandom_range(0, 1) != 0);
          1:       send_sample(4095, $urandom_range(0, 1) != 0);
          default: send_sample($urandom_range(0, 4095), 1'b1);
        endcase
      end
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    blg_pkg::blg_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gauge_expect_q.size() == 0) begin
        $display("%0t: unexpected reading mv=%0d pct=%0d", $time,
                 out_data_o.battery_mv, out_data_o.charge_percent);
        err_count++;
      end else begin
        want = gauge_expect_q.pop_front();
        if (out_data_o.battery_mv !== want.battery_mv) begin
          $display("%0t: battery_mv expected %0d actual %0d", $time,
                   want.battery_mv, out_data_o.battery_mv);
          err_count++;
        end
        if (out_data_o.charge_percent !== want.charge_percent) begin
          $display("%0t: charge_percent expected %0d actual %0d", $time,
                   want.charge_percent, out_data_o.charge_percent);
          err_count++;
        end
      end
    end
  end

  // result receiver: random stalls, plus one long hold on request
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (long_hold_req) begin
        gap = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // reset divider, extremes of the sample fields, empty batch, both curve ends
  task automatic test_directed();
    int unsigned i;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    // one good full-scale sample: far above the top of the curve
    for (i = 0; i < BATCH; i++) send_sample((i == 3) ? 4095 : 0, i == 3);
    // no good sample: no reading
    for (i = 0; i < BATCH; i++) send_sample((i % 2) ? 4095 : 0, 1'b0);
    // all good at zero: bottom of the curve
    for (i = 0; i < BATCH; i++) send_sample(0, 1'b1);
    // largest possible sum
    for (i = 0; i < BATCH; i++) send_sample(4095, 1'b1);
    // exactly at top knee, then just under the bottom knee
    for (i = 0; i < BATCH; i++) send_sample(2100, 1'b1);
    for (i = 0; i < BATCH; i++) send_sample(1499, 1'b1);
    wait_idle();
  endtask

  // divider extremes, including values below unity and zero
  task automatic test_divider_extremes();
    int unsigned divs [6];
    int unsigned d;
    int unsigned b;
    divs = '{100, 1023, 0, 1, 99, 350};
    for (d = 0; d < 6; d++) begin
      write_divider(divs[d]);
      for (b = 0; b < 4; b++) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
        send_batch();
      end
      wait_idle();
    end
  endtask

  // receiver holds off while samples keep coming, so the input must stall
  task automatic test_output_backpressure();
    int unsigned b;
    write_divider(200);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    long_hold_req = 1'b1;
    for (b = 0; b < 12; b++) send_batch();
    wait_idle();
  endtask

  // random batches across random divider settings
  task automatic test_random_batches();
    int unsigned phase;
    int unsigned b;
    for (phase = 0; phase < 8; phase++) begin
      write_divider(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(100, 1023));
      for (b = 0; b < 8; b++) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
        send_batch();
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    divider_x100  = 32'(blg_pkg::DIVR_RESET);
    batch_sum     = 0;
    batch_good    = 0;
    batch_pos     = 0;
    err_count     = 0;
    cycle_count   = 0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_divider_extremes();
    test_output_backpressure();
    test_random_batches();

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
